FILE: hw/rtl/x86_16_instruction_field_decoder_unit_macros.svh
// Assertion macros for the x86 field decoder.
// Clock is clock, synchronous active-high reset is reset; no other dependencies.
`ifndef X86_16_INSTRUCTION_FIELD_DECODER_UNIT_MACROS_SVH
`define X86_16_INSTRUCTION_FIELD_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define X86FD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define X86FD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/x86fd_pkg.sv
// Shared types, codes and opcode form table for the x86 field decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package x86fd_pkg;

   localparam int MaxInstBytes = 6;
   localparam int NumForms     = 12;

   localparam logic [2:0] OP_INVALID = 3'd0;
   localparam logic [2:0] OP_MOV     = 3'd1;
   localparam logic [2:0] OP_ADD     = 3'd2;
   localparam logic [2:0] OP_SUB     = 3'd3;
   localparam logic [2:0] OP_CMP     = 3'd4;

   localparam logic [2:0] FORM_RM_REG  = 3'd0;
   localparam logic [2:0] FORM_IMM_RM  = 3'd1;
   localparam logic [2:0] FORM_IMM_REG = 3'd2;
   localparam logic [2:0] FORM_MEM_ACC = 3'd3;
   localparam logic [2:0] FORM_ACC_MEM = 3'd4;
   localparam logic [2:0] FORM_IMM_ACC = 3'd5;

   // reg field codes of the immediate group
   localparam logic [2:0] GRP_ADD = 3'b000;
   localparam logic [2:0] GRP_SUB = 3'b101;
   localparam logic [2:0] GRP_CMP = 3'b111;

   localparam logic [1:0] DISP_NONE  = 2'd0;
   localparam logic [1:0] DISP_BYTE  = 2'd1;
   localparam logic [1:0] DISP_WORD  = 2'd2;

   typedef struct packed {
      logic [7:0] mask;
      logic [7:0] value;
      logic [2:0] op;
      logic [2:0] form;
      logic       has_modrm;
      logic       has_d;
      logic       has_data;
      logic       has_addr;
      logic       is_group;
      logic       w_bit3;
   } form_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [2:0]  form;
      logic        direction;
      logic        wide;
      logic [1:0]  mode;
      logic [2:0]  reg_field;
      logic [2:0]  rm_field;
      logic [1:0]  disp_kind;
      logic [15:0] displacement;
      logic [15:0] immediate;
      logic [2:0]  length;
   } rec_type;

   typedef logic [MaxInstBytes-1:0][7:0] bytes_type;

   // Form table, index 1..NumForms; index 0 means no form.
   function automatic form_type form_info(input logic [3:0] idx);
      form_type f;
      f = '0;
      case (idx)
         4'd1:  f = '{8'hFC, 8'h88, OP_MOV, FORM_RM_REG,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
         4'd2:  f = '{8'hFE, 8'hC6, OP_MOV, FORM_IMM_RM,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
         4'd3:  f = '{8'hF0, 8'hB0, OP_MOV, FORM_IMM_REG, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
         4'd4:  f = '{8'hFE, 8'hA0, OP_MOV, FORM_MEM_ACC, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
         4'd5:  f = '{8'hFE, 8'hA2, OP_MOV, FORM_ACC_MEM, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
         4'd6:  f = '{8'hFC, 8'h00, OP_ADD, FORM_RM_REG,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
         4'd7:  f = '{8'hFC, 8'h80, OP_INVALID, FORM_IMM_RM,
                      1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
         4'd8:  f = '{8'hFE, 8'h04, OP_ADD, FORM_IMM_ACC, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
         4'd9:  f = '{8'hFC, 8'h28, OP_SUB, FORM_RM_REG,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
         4'd10: f = '{8'hFE, 8'h2C, OP_SUB, FORM_IMM_ACC, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
         4'd11: f = '{8'hFC, 8'h38, OP_CMP, FORM_RM_REG,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
         4'd12: f = '{8'hFE, 8'h3C, OP_CMP, FORM_IMM_ACC, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
         default: f = '0;
      endcase
      return f;
   endfunction

   // First matching form wins; scan backwards so earlier entries override.
   function automatic logic [3:0] form_match(input logic [7:0] b);
      logic [3:0] hit;
      form_type   f;
      hit = '0;
      for (int i = NumForms; i >= 1; i--) begin
         f = form_info(4'(i));
         if ((b & f.mask) == f.value) hit = 4'(i);
      end
      return hit;
   endfunction

   // Displacement bytes implied by a mod/reg/rm byte.
   function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
      logic [1:0] n;
      case (modrm[7:6])
         2'b01:   n = 2'd1;
         2'b10:   n = 2'd2;
         2'b00:   n = (modrm[2:0] == 3'b110) ? 2'd2 : 2'd0;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/x86_16_instruction_field_decoder_unit.sv
// x86 16-bit instruction field decoder: top level, byte register, state, result register.
// Depends on x86fd_pkg, x86fd_decode and the assertion macro header.
//
// Usage:
//   req_ channel carries the code stream, one byte per item (req_code_byte).
//   rsp_ channel carries one decoded record per completed instruction, or an
//   invalid record (operation 0) for an unknown opcode (length 1) or an
//   immediate-group byte pair with an unused reg code (length 2).
//   Throughput: one code byte per cycle, sustained, limited only by the
//   receiver. The decode sits between a one-byte input register and the
//   result register: the last byte of an instruction is held in the input
//   register, and the record decoded from it is then loaded into the result
//   register, which drives rsp_ until the record is taken.
//   When the receiver stalls, the record holds in the result register; the
//   input register takes one more byte if it is empty, and then req_ready
//   drops until the record is taken.
//   Reset (synchronous, active high) empties both registers and drops any
//   partly collected instruction; the next byte is taken as an opcode.
`timescale 1ns / 1ps
`default_nettype none

`include "x86_16_instruction_field_decoder_unit_macros.svh"

module x86_16_instruction_field_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_code_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_operation,
   output logic [2:0]       rsp_form,
   output logic             rsp_direction,
   output logic             rsp_wide,
   output logic [1:0]       rsp_mode,
   output logic [2:0]       rsp_reg_field,
   output logic [2:0]       rsp_rm_field,
   output logic [1:0]       rsp_disp_kind,
   output logic [15:0]      rsp_displacement,
   output logic [15:0]      rsp_immediate,
   output logic [2:0]       rsp_length
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   x86fd_pkg::rec_type    rsp_rec_ff, rsp_rec_in;
   logic [2:0]            taken_ff, taken_in;
   logic [3:0]            form_ff, form_in;
   logic [7:0]            held_ff [x86fd_pkg::MaxInstBytes];

   logic                  advance;
   logic                  process;
   logic                  first;
   logic                  emit;
   logic [3:0]            hit;
   logic [2:0]            taken_new;
   x86fd_pkg::bytes_type  inst_bytes;
   x86fd_pkg::rec_type    dec_rec;
   logic [2:0]            dec_needed;
   logic                  dec_group_bad;

   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign req_ready = ~in_valid_ff | advance;
   assign process   = in_valid_ff & advance;
   assign first     = (taken_ff == 3'd0);
   assign hit       = x86fd_pkg::form_match(in_byte_ff);
   assign taken_new = taken_ff + 3'd1;

   // merge the incoming byte into the held bytes at its slot
   always_comb begin
      for (int i = 0; i < x86fd_pkg::MaxInstBytes; i++) begin
         inst_bytes[i] = (taken_ff == 3'(i)) ? in_byte_ff : held_ff[i];
      end
   end

   x86fd_decode u_decode (
      .form_idx   (first ? hit : form_ff),
      .inst_bytes (inst_bytes),
      .taken_new  (taken_new),
      .rec        (dec_rec),
      .needed     (dec_needed),
      .group_bad  (dec_group_bad)
   );

   always_comb begin
      taken_in   = taken_ff;
      form_in    = form_ff;
      emit       = 1'b0;
      rsp_rec_in = rsp_rec_ff;
      if (process) begin
         if (first) begin
            if (hit == 4'd0) begin
               emit              = 1'b1;
               rsp_rec_in        = '0;
               rsp_rec_in.length = 3'd1;
            end else begin
               taken_in = 3'd1;
               form_in  = hit;
            end
         end else if (dec_group_bad) begin
            emit              = 1'b1;
            rsp_rec_in        = '0;
            rsp_rec_in.length = 3'd2;
            taken_in          = '0;
            form_in           = '0;
         end else if (taken_new >= dec_needed ||
                      taken_new >= 3'(x86fd_pkg::MaxInstBytes)) begin
            emit       = 1'b1;
            rsp_rec_in = dec_rec;
            taken_in   = '0;
            form_in    = '0;
         end else begin
            taken_in = taken_new;
         end
      end
      in_valid_in  = (req_valid & req_ready) ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         taken_ff     <= '0;
         form_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         taken_ff     <= taken_in;
         form_ff      <= form_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_code_byte;
      if (emit) rsp_rec_ff <= rsp_rec_in;
      if (process) held_ff[taken_ff] <= in_byte_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_operation    = rsp_rec_ff.operation;
   assign rsp_form         = rsp_rec_ff.form;
   assign rsp_direction    = rsp_rec_ff.direction;
   assign rsp_wide         = rsp_rec_ff.wide;
   assign rsp_mode         = rsp_rec_ff.mode;
   assign rsp_reg_field    = rsp_rec_ff.reg_field;
   assign rsp_rm_field     = rsp_rec_ff.rm_field;
   assign rsp_disp_kind    = rsp_rec_ff.disp_kind;
   assign rsp_displacement = rsp_rec_ff.displacement;
   assign rsp_immediate    = rsp_rec_ff.immediate;
   assign rsp_length       = rsp_rec_ff.length;

   `X86FD_ASSERT_NOW(a_taken_range, 1'b1,
      taken_ff < 3'(x86fd_pkg::MaxInstBytes), "byte count overran")
   `X86FD_ASSERT_NOW(a_form_tracks_count, 1'b1,
      (taken_ff == 3'd0) == (form_ff == 4'd0), "form and count disagree")
   `X86FD_ASSERT_NOW(a_len_nonzero, rsp_valid, rsp_length != 3'd0, "record with zero length")
   `X86FD_ASSERT_NOW(a_invalid_len,
      rsp_valid && rsp_operation == x86fd_pkg::OP_INVALID,
      rsp_length == 3'd1 || rsp_length == 3'd2, "invalid record with bad length")
   `X86FD_ASSERT_NEXT(a_emit_restarts, emit, taken_ff == 3'd0, "state not cleared after record")

endmodule

`default_nettype wire

FILE: hw/rtl/x86fd_decode.sv
// Field extraction for the x86 field decoder: length so far and the record.
// Depends on x86fd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86fd_decode (
   input  wire logic [3:0]           form_idx,
   input  wire x86fd_pkg::bytes_type inst_bytes,
   input  wire logic [2:0]           taken_new,
   output x86fd_pkg::rec_type        rec,
   output logic [2:0]                needed,
   output logic                      group_bad
);

   x86fd_pkg::form_type f;
   logic [7:0]  b0;
   logic [7:0]  b1;
   logic [1:0]  nd;
   logic        w;
   logic        s;
   logic        data2;
   logic [2:0]  pos;
   logic [15:0] pair;
   logic [7:0]  lone;
   logic [2:0]  op;

   always_comb begin
      f     = x86fd_pkg::form_info(form_idx);
      b0    = inst_bytes[0];
      b1    = inst_bytes[1];
      nd    = x86fd_pkg::disp_bytes(b1);
      w     = f.w_bit3 ? b0[3] : b0[0];
      s     = f.is_group & b0[1];
      data2 = w & ~s;
      pos   = f.has_modrm ? 3'(3'd2 + 3'(nd)) : 3'd1;

      needed = 3'd1;
      if (f.has_modrm) begin
         needed = needed + 3'd1;
         if (taken_new >= 3'd2) needed = needed + 3'(nd);
      end
      if (f.has_data) needed = needed + (data2 ? 3'd2 : 3'd1);
      if (f.has_addr) needed = needed + 3'd2;

      // immediate sits after the addressing byte and displacement, or right after the opcode without one
      case (pos)
         3'd1:    pair = {inst_bytes[2], inst_bytes[1]};
         3'd2:    pair = {inst_bytes[3], inst_bytes[2]};
         3'd3:    pair = {inst_bytes[4], inst_bytes[3]};
         3'd4:    pair = {inst_bytes[5], inst_bytes[4]};
         default: pair = '0;
      endcase
      lone = pair[7:0];

      op        = f.op;
      group_bad = 1'b0;
      if (f.is_group) begin
         case (b1[5:3])
            x86fd_pkg::GRP_ADD: op = x86fd_pkg::OP_ADD;
            x86fd_pkg::GRP_SUB: op = x86fd_pkg::OP_SUB;
            x86fd_pkg::GRP_CMP: op = x86fd_pkg::OP_CMP;
            default:            group_bad = 1'b1;
         endcase
      end

      rec           = '0;
      rec.operation = op;
      rec.form      = f.form;
      rec.direction = f.has_d & b0[1];
      rec.wide      = w;
      rec.length    = needed;
      if (f.has_modrm) begin
         rec.mode      = b1[7:6];
         rec.reg_field = b1[5:3];
         rec.rm_field  = b1[2:0];
         case (nd)
            2'd1: begin
               rec.disp_kind    = x86fd_pkg::DISP_BYTE;
               rec.displacement = {{8{inst_bytes[2][7]}}, inst_bytes[2]};
            end
            2'd2: begin
               rec.disp_kind    = x86fd_pkg::DISP_WORD;
               rec.displacement = {inst_bytes[3], inst_bytes[2]};
            end
            default: begin
               rec.disp_kind    = x86fd_pkg::DISP_NONE;
               rec.displacement = '0;
            end
         endcase
      end else if (f.w_bit3) begin
         rec.reg_field = b0[2:0];
      end

      if (f.has_addr) begin
         rec.immediate = {inst_bytes[2], inst_bytes[1]};
      end else if (f.has_data) begin
         if (data2) rec.immediate = pair;
         else if (s && w) rec.immediate = {{8{lone[7]}}, lone};
         else rec.immediate = {8'h00, lone};
      end
   end

endmodule

`default_nettype wire

FILE: dv/tb_x86_16_instruction_field_decoder_unit.sv
// Self-checking testbench for the x86 16-bit instruction field decoder.
// Byte-level predictor, directed and random code streams, random stalls on both sides.
// Depends on x86fd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_x86_16_instruction_field_decoder_unit;

   localparam int RandomBytes = 1700;
   localparam int NumPatterns = 12;

   // Opcode patterns in match priority order
   localparam logic [0:11][7:0] PAT_MASK = {
      8'hFC, 8'hFE, 8'hF0, 8'hFE, 8'hFE, 8'hFC, 8'hFC, 8'hFE, 8'hFC, 8'hFE, 8'hFC, 8'hFE};
   localparam logic [0:11][7:0] PAT_VALUE = {
      8'h88, 8'hC6, 8'hB0, 8'hA0, 8'hA2, 8'h00, 8'h80, 8'h04, 8'h28, 8'h2C, 8'h38, 8'h3C};
   localparam logic [0:11][2:0] PAT_OP = {
      x86fd_pkg::OP_MOV, x86fd_pkg::OP_MOV, x86fd_pkg::OP_MOV, x86fd_pkg::OP_MOV,
      x86fd_pkg::OP_MOV, x86fd_pkg::OP_ADD, x86fd_pkg::OP_INVALID, x86fd_pkg::OP_ADD,
      x86fd_pkg::OP_SUB, x86fd_pkg::OP_SUB, x86fd_pkg::OP_CMP, x86fd_pkg::OP_CMP};
   localparam logic [0:11][2:0] PAT_FORM = {
      x86fd_pkg::FORM_RM_REG, x86fd_pkg::FORM_IMM_RM, x86fd_pkg::FORM_IMM_REG,
      x86fd_pkg::FORM_MEM_ACC, x86fd_pkg::FORM_ACC_MEM, x86fd_pkg::FORM_RM_REG,
      x86fd_pkg::FORM_IMM_RM, x86fd_pkg::FORM_IMM_ACC, x86fd_pkg::FORM_RM_REG,
      x86fd_pkg::FORM_IMM_ACC, x86fd_pkg::FORM_RM_REG, x86fd_pkg::FORM_IMM_ACC};
   localparam logic [0:11] PAT_MODRM = 12'b1100_0110_1010;
   localparam logic [0:11] PAT_D     = 12'b1000_0100_1010;
   localparam logic [0:11] PAT_DATA  = 12'b0110_0011_0101;
   localparam logic [0:11] PAT_ADDR  = 12'b0001_1000_0000;
   localparam logic [0:11] PAT_GROUP = 12'b0000_0010_0000;
   localparam logic [0:11] PAT_WBIT3 = 12'b0010_0000_0000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_code_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_operation;
   logic [2:0]  rsp_form;
   logic        rsp_direction;
   logic        rsp_wide;
   logic [1:0]  rsp_mode;
   logic [2:0]  rsp_reg_field;
   logic [2:0]  rsp_rm_field;
   logic [1:0]  rsp_disp_kind;
   logic [15:0] rsp_displacement;
   logic [15:0] rsp_immediate;
   logic [2:0]  rsp_length;

   // Instruction being collected by the predictor
   logic [7:0]  pend_bytes [x86fd_pkg::MaxInstBytes];
   int          pend_count = 0;
   int          pend_pat = 0;

   x86fd_pkg::rec_type decoded_q [$];
   x86fd_pkg::rec_type want_rec;
   x86fd_pkg::rec_type got_rec;
   int          errors = 0;
   int          bytes_sent = 0;
   bit          calm = 1'b0;

   x86_16_instruction_field_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_operation    (rsp_operation),
      .rsp_form         (rsp_form),
      .rsp_direction    (rsp_direction),
      .rsp_wide         (rsp_wide),
      .rsp_mode         (rsp_mode),
      .rsp_reg_field    (rsp_reg_field),
      .rsp_rm_field     (rsp_rm_field),
      .rsp_disp_kind    (rsp_disp_kind),
      .rsp_displacement (rsp_displacement),
      .rsp_immediate    (rsp_immediate),
      .rsp_length       (rsp_length)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int disp_len(input logic [7:0] m);
      case (m[7:6])
         2'b01:   return 1;
         2'b10:   return 2;
         2'b00:   return (m[2:0] == 3'b110) ? 2 : 0;
         default: return 0;
      endcase
   endfunction

   function automatic logic is_wide(input int p, input logic [7:0] op0);
      return PAT_WBIT3[p] ? op0[3] : op0[0];
   endfunction

   // s set with w set shrinks the group immediate to one byte
   function automatic int data_len(input int p, input logic [7:0] op0);
      return (is_wide(p, op0) && !(PAT_GROUP[p] && op0[1])) ? 2 : 1;
   endfunction

   function automatic int total_len(input int p);
      int n;
      n = 1;
      if (PAT_MODRM[p]) begin
         n++;
         if (pend_count >= 2) n += disp_len(pend_bytes[1]);
      end
      if (PAT_DATA[p]) n += data_len(p, pend_bytes[0]);
      if (PAT_ADDR[p]) n += 2;
      return n;
   endfunction

   function automatic x86fd_pkg::rec_type build_record(input int p, input logic [2:0] op);
      x86fd_pkg::rec_type r;
      logic [7:0] b0;
      logic [7:0] b1;
      int         pos;
      int         nd;
      int         q;
      r = '0;
      b0 = pend_bytes[0];
      b1 = pend_bytes[1];
      pos = 1;
      r.operation = op;
      r.form = PAT_FORM[p];
      r.wide = is_wide(p, b0);
      r.direction = PAT_D[p] ? b0[1] : 1'b0;
      if (PAT_MODRM[p]) begin
         nd = disp_len(b1);
         r.mode = b1[7:6];
         r.reg_field = b1[5:3];
         r.rm_field = b1[2:0];
         if (nd == 1) begin
            r.disp_kind = x86fd_pkg::DISP_BYTE;
            r.displacement = {{8{pend_bytes[2][7]}}, pend_bytes[2]};
         end else if (nd == 2) begin
            r.disp_kind = x86fd_pkg::DISP_WORD;
            r.displacement = {pend_bytes[3], pend_bytes[2]};
         end
         pos = 2 + nd;
      end else if (PAT_WBIT3[p]) begin
         r.reg_field = b0[2:0];
      end
      if (PAT_ADDR[p]) begin
         r.immediate = {pend_bytes[2], pend_bytes[1]};
      end else if (PAT_DATA[p]) begin
         q = pos % x86fd_pkg::MaxInstBytes;
         if (data_len(p, b0) == 2)
            r.immediate = {pend_bytes[(q + 1) % x86fd_pkg::MaxInstBytes], pend_bytes[q]};
         else if (PAT_GROUP[p] && b0[1] && r.wide)
            r.immediate = {{8{pend_bytes[q][7]}}, pend_bytes[q]};
         else
            r.immediate = {8'h00, pend_bytes[q]};
      end
      r.length = 3'(total_len(p));
      return r;
   endfunction

   // Advance the predicted decoder by one accepted byte
   task automatic decode_byte(input logic [7:0] b);
      int         hit;
      int         p;
      logic [2:0] op;
      x86fd_pkg::rec_type r;
      bit         bad_group;
      r = '0;
      if (pend_count == 0) begin
         hit = -1;
         for (int i = 0; i < NumPatterns; i++)
            if (hit < 0 && (b & PAT_MASK[i]) == PAT_VALUE[i]) hit = i;
         if (hit < 0) begin
            r.length = 3'd1;
            decoded_q.push_back(r);
         end else begin
            pend_bytes[0] = b;
            pend_count = 1;
            pend_pat = hit;
         end
      end else begin
         p = pend_pat;
         if (pend_count < x86fd_pkg::MaxInstBytes) pend_bytes[pend_count] = b;
         pend_count++;
         op = PAT_OP[p];
         bad_group = 1'b0;
         if (PAT_GROUP[p]) begin
            case (pend_bytes[1][5:3])
               x86fd_pkg::GRP_ADD: op = x86fd_pkg::OP_ADD;
               x86fd_pkg::GRP_SUB: op = x86fd_pkg::OP_SUB;
               x86fd_pkg::GRP_CMP: op = x86fd_pkg::OP_CMP;
               default:            bad_group = 1'b1;
            endcase
         end
         if (bad_group) begin
            r.length = 3'd2;
            decoded_q.push_back(r);
            pend_count = 0;
         end else if (pend_count >= total_len(p) ||
                      pend_count >= x86fd_pkg::MaxInstBytes) begin
            decoded_q.push_back(build_record(p, op));
            pend_count = 0;
         end
      end
   endtask

   // Entered and left at a falling edge; valid stays up for a back-to-back item
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (decoded_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] field_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_instruction(input int p);
      logic [7:0] op0;
      logic [7:0] m;
      op0 = PAT_VALUE[p] | (8'($urandom) & ~PAT_MASK[p]);
      send_byte(op0);
      if (PAT_MODRM[p]) begin
         m = 8'($urandom);
         if ($urandom_range(0, 7) == 0) m = {2'b00, m[5:3], 3'b110};
         if (PAT_GROUP[p] && $urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 2))
               0:       m[5:3] = x86fd_pkg::GRP_ADD;
               1:       m[5:3] = x86fd_pkg::GRP_SUB;
               default: m[5:3] = x86fd_pkg::GRP_CMP;
            endcase
         end
         send_byte(m);
      end
      // fill in displacement and immediate until the instruction closes
      while (pend_count != 0) send_byte(field_byte());
   endtask

   task automatic test_invalid_opcodes();
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h08);
   endtask

   task automatic test_modrm_forms();
      send_byte(8'h00);
      send_byte(8'hC0);
      send_byte(8'h8B);
      send_byte(8'h46);
      send_byte(8'h80);
      // mov imm-regmem with a non-zero reg field, 16-bit displacement and data
      send_byte(8'hC7);
      send_byte(8'hB8);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h80);
   endtask

   task automatic test_immediate_group();
      // direct address, then a sign-extended byte immediate
      send_byte(8'h83);
      send_byte(8'h06);
      send_byte(8'h34);
      send_byte(8'h12);
      send_byte(8'hFF);
      // s set with w clear: byte immediate, no extension
      send_byte(8'h82);
      send_byte(8'hE8);
      send_byte(8'h80);
   endtask

   task automatic test_accumulator_forms();
      send_byte(8'hA1);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h3D);
      send_byte(8'hFF);
      send_byte(8'h7F);
   endtask

   task automatic test_random_stream();
      int         first;
      int         done;
      int         sel;
      bit         paused;
      logic [7:0] m;
      first = bytes_sent;
      paused = 1'b0;
      done = 0;
      while (done < RandomBytes) begin
         calm = (done >= 500 && done < 800);
         if (!paused && done >= 1100) begin
            wait_drained();
            paused = 1'b1;
         end
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            send_byte(8'($urandom));
         end else if (sel < 12) begin
            send_byte(8'h80 | 8'($urandom_range(0, 3)));
            do m = 8'($urandom);
            while (m[5:3] == x86fd_pkg::GRP_ADD || m[5:3] == x86fd_pkg::GRP_SUB ||
                   m[5:3] == x86fd_pkg::GRP_CMP);
            send_byte(m);
         end else begin
            send_instruction($urandom_range(0, NumPatterns - 1));
         end
         done = bytes_sent - first;
      end
      calm = 1'b0;
   endtask

   always @(negedge clock) rsp_ready <= calm || ($urandom_range(0, 99) >= 22);

   function automatic void check_field(input string name, input int unsigned want_v,
                                       input int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_rec = {rsp_operation, rsp_form, rsp_direction, rsp_wide, rsp_mode,
                    rsp_reg_field, rsp_rm_field, rsp_disp_kind, rsp_displacement,
                    rsp_immediate, rsp_length};
         if (decoded_q.size() == 0) begin
            $display("%0t: record with none expected, actual %p", $time, got_rec);
            errors++;
         end else begin
            want_rec = decoded_q.pop_front();
            check_field("operation", want_rec.operation, got_rec.operation);
            check_field("form", want_rec.form, got_rec.form);
            check_field("direction", want_rec.direction, got_rec.direction);
            check_field("wide", want_rec.wide, got_rec.wide);
            check_field("mode", want_rec.mode, got_rec.mode);
            check_field("reg_field", want_rec.reg_field, got_rec.reg_field);
            check_field("rm_field", want_rec.rm_field, got_rec.rm_field);
            check_field("disp_kind", want_rec.disp_kind, got_rec.disp_kind);
            check_field("displacement", want_rec.displacement, got_rec.displacement);
            check_field("immediate", want_rec.immediate, got_rec.immediate);
            check_field("length", want_rec.length, got_rec.length);
         end
      end
   end

   initial begin
      for (int i = 0; i < x86fd_pkg::MaxInstBytes; i++) pend_bytes[i] = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_invalid_opcodes();
      test_modrm_forms();
      test_immediate_group();
      test_accumulator_forms();
      test_random_stream();
      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("x86_16_instruction_field_decoder_unit test passed");
      else
         $display("x86_16_instruction_field_decoder_unit test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("x86_16_instruction_field_decoder_unit test failed");
      $finish;
   end

endmodule
